// ===== rtl/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared sizes, operation and status codes, and cell control modes.
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int DEPTH  = 64;
   localparam int DATA_W = 32;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int LEN_W  = 7;
   localparam int OP_W   = 3;
   localparam int STAT_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_POP_BACK   = 3'd1,
      OP_PUSH_FRONT = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_DUMP       = 3'd4,
      OP_CLEAR      = 3'd5
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_DONE  = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_FROM_LEFT,
      CELL_FROM_RIGHT,
      CELL_LOAD
   } cell_mode_type;

   typedef enum logic {
      ST_IDLE,
      ST_DUMP
   } state_type;

endpackage

// ===== rtl/dq_cell.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue cell
// Holds one stored value and takes a new one from a neighbor or the load bus.
// ----------------------------------------------------------------------------
module dq_cell (
   input  logic                              clock,
   input  dq_pkg::cell_mode_type             mode,
   input  logic signed [dq_pkg::DATA_W-1:0]  left_data,
   input  logic signed [dq_pkg::DATA_W-1:0]  right_data,
   input  logic signed [dq_pkg::DATA_W-1:0]  load_data,
   output logic signed [dq_pkg::DATA_W-1:0]  data
);

   logic signed [dq_pkg::DATA_W-1:0] data_ff;

   always_ff @(posedge clock) begin
      case (mode)
         dq_pkg::CELL_FROM_LEFT:  data_ff <= left_data;
         dq_pkg::CELL_FROM_RIGHT: data_ff <= right_data;
         dq_pkg::CELL_LOAD:       data_ff <= load_data;
         default:                 data_ff <= data_ff;
      endcase
   end

   assign data = data_ff;

endmodule

// ===== rtl/double_ended_queue_top.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue top level
// Bounded deque of signed values kept in a row of cells, front at cell zero.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_ready   req_operation, req_value
//   rsp_      out        rsp_valid/rsp_ready   rsp_value_res, rsp_status,
//                                              rsp_is_element, rsp_last,
//                                              rsp_length
//
// Push, pop, clear, unknown codes and a dump of an empty queue give one
// response, registered at the accepting edge.
// A dump of N values holds off requests until its last value is registered,
// one value per cycle while the response is not stalled, as the cell row
// rotates by one position per response; the row is back in order afterward.
// Synchronous reset empties the queue; stored values are not cleared.
// A stalled response holds the row and the dump counter in place.
// ----------------------------------------------------------------------------
module double_ended_queue_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [dq_pkg::OP_W-1:0]           req_operation,
   input  logic signed [dq_pkg::DATA_W-1:0]  req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [dq_pkg::DATA_W-1:0]  rsp_value_res,
   output logic [dq_pkg::STAT_W-1:0]         rsp_status,
   output logic                              rsp_is_element,
   output logic                              rsp_last,
   output logic [dq_pkg::LEN_W-1:0]          rsp_length
);

   dq_pkg::state_type                 state_ff, state_in;
   logic [dq_pkg::CNT_W-1:0]          count_ff, count_in;
   logic [dq_pkg::CNT_W-1:0]          remain_ff, remain_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [dq_pkg::DATA_W-1:0]  value_ff, value_in;
   dq_pkg::status_type                status_ff, status_in;
   logic                              elem_ff, elem_in;
   logic                              last_ff, last_in;
   logic [dq_pkg::CNT_W-1:0]          length_ff, length_in;

   logic                              out_free;
   logic                              full;
   logic                              empty;
   logic signed [dq_pkg::DATA_W-1:0]  load_data;
   dq_pkg::cell_mode_type             cell_mode [dq_pkg::DEPTH];
   logic signed [dq_pkg::DATA_W-1:0]  cell_data [dq_pkg::DEPTH];

   genvar g;
   generate
      for (g = 0; g < dq_pkg::DEPTH; g++) begin : g_cell
         logic signed [dq_pkg::DATA_W-1:0] left_data;
         logic signed [dq_pkg::DATA_W-1:0] right_data;
         if (g == 0) begin : g_first
            assign left_data = load_data;
         end else begin : g_mid
            assign left_data = cell_data[g-1];
         end
         if (g == dq_pkg::DEPTH - 1) begin : g_last
            assign right_data = '0;
         end else begin : g_inner
            assign right_data = cell_data[g+1];
         end
         dq_cell u_cell (
            .clock      (clock),
            .mode       (cell_mode[g]),
            .left_data  (left_data),
            .right_data (right_data),
            .load_data  (load_data),
            .data       (cell_data[g])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dq_pkg::ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      status_ff <= status_in;
      elem_ff   <= elem_in;
      last_ff   <= last_in;
      length_ff <= length_in;
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign full     = (count_ff == dq_pkg::CNT_W'(dq_pkg::DEPTH));
   assign empty    = (count_ff == '0);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      value_in     = value_ff;
      status_in    = status_ff;
      elem_in      = elem_ff;
      last_in      = last_ff;
      length_in    = length_ff;
      load_data    = req_value;
      req_ready    = 1'b0;
      for (int i = 0; i < dq_pkg::DEPTH; i++) begin
         cell_mode[i] = dq_pkg::CELL_HOLD;
      end

      unique case (state_ff)
         dq_pkg::ST_IDLE: begin
            req_ready = out_free;
            if (req_valid && out_free) begin
               rsp_valid_in = 1'b1;
               value_in     = '0;
               status_in    = dq_pkg::STAT_DONE;
               elem_in      = 1'b0;
               last_in      = 1'b1;
               case (dq_pkg::op_type'(req_operation))
                  dq_pkg::OP_PUSH_BACK: begin
                     if (full) begin
                        status_in = dq_pkg::STAT_FULL;
                     end else begin
                        count_in = count_ff + 1'b1;
                        for (int i = 0; i < dq_pkg::DEPTH; i++) begin
                           if (count_ff == dq_pkg::CNT_W'(i)) begin
                              cell_mode[i] = dq_pkg::CELL_LOAD;
                           end
                        end
                     end
                  end
                  dq_pkg::OP_POP_BACK: begin
                     if (empty) begin
                        status_in = dq_pkg::STAT_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  dq_pkg::OP_PUSH_FRONT: begin
                     if (full) begin
                        status_in = dq_pkg::STAT_FULL;
                     end else begin
                        count_in = count_ff + 1'b1;
                        for (int i = 0; i < dq_pkg::DEPTH; i++) begin
                           cell_mode[i] = (i == 0) ? dq_pkg::CELL_LOAD
                                                   : dq_pkg::CELL_FROM_LEFT;
                        end
                     end
                  end
                  dq_pkg::OP_POP_FRONT: begin
                     if (empty) begin
                        status_in = dq_pkg::STAT_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                        for (int i = 0; i < dq_pkg::DEPTH; i++) begin
                           cell_mode[i] = dq_pkg::CELL_FROM_RIGHT;
                        end
                     end
                  end
                  dq_pkg::OP_DUMP: begin
                     if (!empty) begin
                        rsp_valid_in = 1'b0;
                        remain_in    = count_ff;
                        state_in     = dq_pkg::ST_DUMP;
                     end
                  end
                  dq_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
               length_in = count_in;
            end
         end
         dq_pkg::ST_DUMP: begin
            load_data = cell_data[0];
            if (out_free) begin
               rsp_valid_in = 1'b1;
               value_in     = cell_data[0];
               status_in    = dq_pkg::STAT_DONE;
               elem_in      = 1'b1;
               last_in      = (remain_ff == dq_pkg::CNT_W'(1));
               length_in    = count_ff;
               remain_in    = remain_ff - 1'b1;
               if (remain_ff == dq_pkg::CNT_W'(1)) begin
                  state_in = dq_pkg::ST_IDLE;
               end
               for (int i = 0; i < dq_pkg::DEPTH; i++) begin
                  if (dq_pkg::CNT_W'(i + 1) < count_ff) begin
                     cell_mode[i] = dq_pkg::CELL_FROM_RIGHT;
                  end else if (dq_pkg::CNT_W'(i + 1) == count_ff) begin
                     cell_mode[i] = dq_pkg::CELL_LOAD;
                  end
               end
            end
         end
         default: begin
            state_in = dq_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value_res  = value_ff;
   assign rsp_status     = status_ff;
   assign rsp_is_element = elem_ff;
   assign rsp_last       = last_ff;
   assign rsp_length     = dq_pkg::LEN_W'(length_ff);

endmodule
